// ----- rtl/sck_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sck_pkg
// Shared types, constants and helpers for the soft color key alpha pipeline.
// ----------------------------------------------------------------------------
package sck_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 4 * CH_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_RED   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_GREEN = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_BLUE  = 2'd3;

  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ZERO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RAMP = 2'd2;

  // squared distance
  localparam int SQ_W      = 2 * CH_W;
  localparam int D2_W      = SQ_W + 2;
  localparam int D2_RAMP_W = 10;
  localparam int D2_LOW    = 36;
  localparam int D2_HIGH   = 576;

  // square root, 12 fraction bits, result below 32.0
  localparam int FRAC_BITS = 12;
  localparam int ROOT_W    = 17;
  localparam int REM_W     = 35;
  localparam int SQ_STEPS  = ROOT_W;
  localparam logic [ROOT_W-1:0] LOW_FX  = ROOT_W'(6 << FRAC_BITS);
  localparam logic [ROOT_W-1:0] HIGH_FX = ROOT_W'(24 << FRAC_BITS);

  // ramp: (a*(R-LOW_FX) + 9*4096) / (18*4096) = ((num >> 13) / 9)
  localparam int NUM_W     = 25;
  localparam int HALF_SPAN = 9 << FRAC_BITS;
  localparam int X_W       = NUM_W - (FRAC_BITS + 1);
  localparam int RECIP9    = 3641;
  localparam int P_W       = 23;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_t;

  typedef struct packed {
    logic            enable;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } key_t;

  typedef struct packed {
    pix_t              pix;
    logic [MODE_W-1:0] mode;
  } beat_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // one digit of the bitwise integer square root, result bit k
  function automatic sq_t sqrt_step(sq_t s, int unsigned k);
    logic [REM_W-1:0] trial;
    sq_t              o;
    trial = (REM_W'(s.root) << (k + 1)) | (REM_W'(1) << (2 * k));
    o = s;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = s.root | (ROOT_W'(1) << k);
    end
    return o;
  endfunction

endpackage

// ----- rtl/sck_dist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sck_dist
// Three-stage squared RGB distance to the key and ramp mode select.
// ----------------------------------------------------------------------------
module sck_dist
  import sck_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  key_t                 key,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pix_t                 in_pix,
  output logic                 out_valid,
  input  logic                 out_ready,
  output beat_t                out_beat,
  output logic [D2_RAMP_W-1:0] out_d2
);

  logic v0_r, v1_r, v2_r;
  logic adv0, adv1, adv2;

  pix_t            pix0_r, pix1_r;
  logic            en0_r, en1_r;
  logic [CH_W-1:0] ad_r [3];
  logic [SQ_W-1:0] sq_r [3];

  beat_t                beat2_r;
  logic [D2_RAMP_W-1:0] d2_2_r;

  logic [D2_W-1:0]   sum;
  logic [MODE_W-1:0] mode;

  function automatic logic [CH_W-1:0] absdiff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign adv2     = !v2_r || out_ready;
  assign adv1     = !v1_r || adv2;
  assign adv0     = !v0_r || adv1;
  assign in_ready = adv0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv0) v0_r <= in_valid;
      if (adv1) v1_r <= v0_r;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_comb begin
    sum = D2_W'(sq_r[0]) + D2_W'(sq_r[1]) + D2_W'(sq_r[2]);
    if (!en1_r) begin
      mode = MODE_PASS;
    end else if (sum <= D2_W'(D2_LOW)) begin
      mode = MODE_ZERO;
    end else if (sum >= D2_W'(D2_HIGH)) begin
      mode = MODE_PASS;
    end else begin
      mode = MODE_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      pix0_r <= in_pix;
      en0_r  <= key.enable;
      ad_r[0] <= absdiff(in_pix.red, key.red);
      ad_r[1] <= absdiff(in_pix.green, key.green);
      ad_r[2] <= absdiff(in_pix.blue, key.blue);
    end
    if (adv1) begin
      pix1_r  <= pix0_r;
      en1_r   <= en0_r;
      sq_r[0] <= SQ_W'(ad_r[0]) * SQ_W'(ad_r[0]);
      sq_r[1] <= SQ_W'(ad_r[1]) * SQ_W'(ad_r[1]);
      sq_r[2] <= SQ_W'(ad_r[2]) * SQ_W'(ad_r[2]);
    end
    if (adv2) begin
      beat2_r.pix  <= pix1_r;
      beat2_r.mode <= mode;
      d2_2_r       <= sum[D2_RAMP_W-1:0];
    end
  end

  assign out_valid = v2_r;
  assign out_beat  = beat2_r;
  assign out_d2    = d2_2_r;

endmodule

// ----- rtl/sck_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sck_sqrt
// Pipelined integer square root of d2 << 24, one result bit per stage.
// ----------------------------------------------------------------------------
module sck_sqrt
  import sck_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  beat_t                in_beat,
  input  logic [D2_RAMP_W-1:0] in_d2,
  output logic                 out_valid,
  input  logic                 out_ready,
  output beat_t                out_beat,
  output logic [ROOT_W-1:0]    out_root
);

  logic [SQ_STEPS-1:0] vld_r;
  logic [SQ_STEPS-1:0] adv;
  sq_t                 sq_r   [SQ_STEPS];
  beat_t               beat_r [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_stage
    sq_t   sq_in;
    beat_t beat_in;
    logic  v_in;

    if (i == 0) begin : g_first
      assign sq_in   = '{rem: REM_W'(in_d2) << (2 * FRAC_BITS), root: '0};
      assign beat_in = in_beat;
      assign v_in    = in_valid;
    end else begin : g_next
      assign sq_in   = sq_r[i-1];
      assign beat_in = beat_r[i-1];
      assign v_in    = vld_r[i-1];
    end

    if (i == SQ_STEPS - 1) begin : g_last
      assign adv[i] = !vld_r[i] || out_ready;
    end else begin : g_mid
      assign adv[i] = !vld_r[i] || adv[i+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv[i]) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        sq_r[i]   <= sqrt_step(sq_in, SQ_STEPS - 1 - i);
        beat_r[i] <= beat_in;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[SQ_STEPS-1];
  assign out_beat  = beat_r[SQ_STEPS-1];
  assign out_root  = sq_r[SQ_STEPS-1].root;

endmodule

// ----- rtl/sck_ramp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sck_ramp
// Alpha ramp: scale by root offset, divide by 18*4096 with rounding, select.
// ----------------------------------------------------------------------------
module sck_ramp
  import sck_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  beat_t             in_beat,
  input  logic [ROOT_W-1:0] in_root,
  output logic              out_valid,
  input  logic              out_ready,
  output pix_t              out_pix
);

  logic v0_r, v1_r, v2_r;
  logic adv0, adv1, adv2;

  beat_t            beat0_r, beat1_r;
  logic [NUM_W-1:0] num0_r;
  logic [P_W-1:0]   p1_r;
  pix_t             pix2_r;

  logic [ROOT_W-1:0] diff;
  logic [NUM_W-1:0]  num;
  logic [CH_W-1:0]   q;
  pix_t              pix_nxt;

  assign adv2     = !v2_r || out_ready;
  assign adv1     = !v1_r || adv2;
  assign adv0     = !v0_r || adv1;
  assign in_ready = adv0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv0) v0_r <= in_valid;
      if (adv1) v1_r <= v0_r;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_comb begin
    diff = in_root - LOW_FX;
    num  = NUM_W'(in_beat.pix.alpha) * NUM_W'(diff) + NUM_W'(HALF_SPAN);
    // floor(x/9) = (x*3641) >> 15, exact for x below 32768
    q    = p1_r[P_W-1 -: CH_W];
    pix_nxt = beat1_r.pix;
    case (beat1_r.mode)
      MODE_ZERO: pix_nxt.alpha = '0;
      MODE_RAMP: pix_nxt.alpha = q;
      default:   pix_nxt.alpha = beat1_r.pix.alpha;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      beat0_r <= in_beat;
      num0_r  <= num;
    end
    if (adv1) begin
      beat1_r <= beat0_r;
      p1_r    <= P_W'(num0_r[NUM_W-1 -: X_W]) * P_W'(RECIP9);
    end
    if (adv2) begin
      pix2_r <= pix_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_pix   = pix2_r;

endmodule

// ----- rtl/soft_color_key_alpha.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_color_key_alpha
// RGBA8 pixel stream; alpha lowered by a soft ramp on distance to a key color.
// ----------------------------------------------------------------------------
// channel   dir  beat fields
// in_*      in   tdata: red, green, blue, alpha (8 bits each, red lowest)
// out_*     out  tdata: out_red, out_green, out_blue, out_alpha (red lowest)
// cfg_*     in   write: addr 0 enable, 1 key red, 2 key green, 3 key blue
//
// One pixel per cycle sustained while the output is ready; 3 distance stages,
// 17 square root stages, one result bit each, and 3 ramp stages.
// Reset is synchronous, active low; clears valid bits and key registers.
// A stalled output holds; bubbles ahead of it still fill, so input is taken
// until every stage holds a beat.
// ----------------------------------------------------------------------------
module soft_color_key_alpha
  import sck_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // red, green, blue, alpha
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // out_red, out_green, out_blue, out_alpha
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  key_t key_r;

  logic                 dist_vld, dist_rdy;
  beat_t                dist_beat;
  logic [D2_RAMP_W-1:0] dist_d2;

  logic              sq_vld, sq_rdy;
  beat_t             sq_beat;
  logic [ROOT_W-1:0] sq_root;

  pix_t out_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENABLE:    key_r.enable <= cfg_wdata[0];
        REG_KEY_RED:   key_r.red    <= cfg_wdata;
        REG_KEY_GREEN: key_r.green  <= cfg_wdata;
        REG_KEY_BLUE:  key_r.blue   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sck_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (key_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pix    (pix_t'(in_tdata)),
    .out_valid (dist_vld),
    .out_ready (dist_rdy),
    .out_beat  (dist_beat),
    .out_d2    (dist_d2)
  );

  sck_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dist_vld),
    .in_ready  (dist_rdy),
    .in_beat   (dist_beat),
    .in_d2     (dist_d2),
    .out_valid (sq_vld),
    .out_ready (sq_rdy),
    .out_beat  (sq_beat),
    .out_root  (sq_root)
  );

  sck_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_vld),
    .in_ready  (sq_rdy),
    .in_beat   (sq_beat),
    .in_root   (sq_root),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix)
  );

  assign out_tdata = PIX_W'(out_pix);

`ifndef ASSERT_OFF
  a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
    dist_vld && dist_beat.mode == MODE_RAMP |->
      dist_d2 > D2_RAMP_W'(D2_LOW) && dist_d2 < D2_RAMP_W'(D2_HIGH))
    else $error("ramp beat with distance outside ramp band");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    sq_vld && sq_beat.mode == MODE_RAMP |-> sq_root > LOW_FX && sq_root < HIGH_FX)
    else $error("square root out of ramp band");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready && dist_rdy && sq_rdy)
    else $error("pipeline stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !sq_vld && !dist_vld)
    else $error("valid beat right after reset");
`endif

endmodule

// ----- dv/soft_color_key_alpha_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_color_key_alpha_test
// Stream test of the color key alpha ramp. Pixels are sent in random bursts
// under several key settings. Settings include keying off, the corner keys
// and odd enable values. Most random pixels land near the key, so the zero
// band, the ramp and both of its edges are hit often. A scoreboard predicts
// every output beat and checks it field by field. The receiver stalls on
// its own pattern, with one long hold-off that backs the pipe up.
// ----------------------------------------------------------------------------
module soft_color_key_alpha_test;
  import sck_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 400;

  localparam int ZERO_D2   = 36;
  localparam int KEEP_D2   = 576;
  localparam int FX_ONE    = 4096;
  localparam int FX_FLOOR  = 6 * FX_ONE;
  localparam int FX_SPAN   = 18 * FX_ONE;

  class alpha_key_scoreboard;
    logic        key_on;
    logic [7:0]  key_r;
    logic [7:0]  key_g;
    logic [7:0]  key_b;
    pix_t        alpha_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned n_pass;
    int unsigned n_zero;
    int unsigned n_ramp;
    int unsigned n_keep;

    function new();
      key_on = 1'b0;
      key_r  = '0;
      key_g  = '0;
      key_b  = '0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
      case (idx)
        REG_ENABLE:    key_on = val[0];
        REG_KEY_RED:   key_r  = val;
        REG_KEY_GREEN: key_g  = val;
        REG_KEY_BLUE:  key_b  = val;
        default: ;
      endcase
    endfunction

    function logic [17:0] sq_diff(logic [7:0] a, logic [7:0] b);
      logic [17:0] d;
      d = (a > b) ? 18'(a - b) : 18'(b - a);
      return d * d;
    endfunction

    // floor(sqrt(d2) * 4096), one result bit per pass
    function logic [16:0] fx_root(logic [17:0] d2);
      logic [63:0] v;
      logic [63:0] t;
      logic [16:0] r;
      v = 64'(d2) << 24;
      r = '0;
      for (int k = 16; k >= 0; k--) begin
        t = 64'(r | (17'd1 << k));
        if (t * t <= v) r = r | (17'd1 << k);
      end
      return r;
    endfunction

    function pix_t keyed(pix_t p);
      pix_t        o;
      logic [17:0] d2;
      logic [31:0] num;
      o = p;
      if (!key_on) begin
        n_pass++;
        return o;
      end
      d2 = sq_diff(p.red, key_r) + sq_diff(p.green, key_g) + sq_diff(p.blue, key_b);
      if (d2 <= ZERO_D2) begin
        o.alpha = '0;
        n_zero++;
      end else if (d2 < KEEP_D2) begin
        num = 32'(p.alpha) * (32'(fx_root(d2)) - 32'(FX_FLOOR)) + 32'(FX_SPAN / 2);
        o.alpha = 8'(num / FX_SPAN);
        n_ramp++;
      end else begin
        n_keep++;
      end
      return o;
    endfunction

    function void note_pixel(pix_t p);
      alpha_q.push_back(keyed(p));
    endfunction

    function void check_pixel(pix_t got);
      pix_t want;
      checked++;
      if (alpha_q.size() == 0) begin
        $error("unexpected beat %h", got);
        errors++;
        return;
      end
      want = alpha_q.pop_front();
      if (got.red !== want.red) begin
        $error("out_red: expected %0d, got %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("out_green: expected %0d, got %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("out_alpha: expected %0d, got %0d", want.alpha, got.alpha);
        errors++;
      end
    endfunction

    function int pending();
      return alpha_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;   // red, green, blue, alpha
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;       // out_red, out_green, out_blue, out_alpha
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  alpha_key_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_cycle = 0;
  int unsigned hold_cnt = 0;
  int unsigned n_settings = 1;
  bit          hold_req = 1'b0;

  soft_color_key_alpha dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats pending", cycle_cnt, sb.pending());
      $display("soft_color_key_alpha: mismatch");
      $finish;
    end
  end

  // receiver: checks beats and stalls on its own pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(pix_t'(out_tdata));
    rx_cycle++;
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 256) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_cycle % 5 != 0);
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
  endtask

  task automatic write_key(input logic [7:0] en, input logic [7:0] kr,
                           input logic [7:0] kg, input logic [7:0] kb);
    write_reg(REG_ENABLE, en);
    write_reg(REG_KEY_RED, kr);
    write_reg(REG_KEY_GREEN, kg);
    write_reg(REG_KEY_BLUE, kb);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic send_pixel(input pix_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel(p);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] near(logic [7:0] k, int spread);
    int v;
    v = int'(k) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic pix_t pick_pixel();
    pix_t p;
    int   spread;
    p = pix_t'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: spread = 24;
      5:             spread = 7;
      6:             spread = 0;
      default:       spread = -1;
    endcase
    if (spread >= 0) begin
      p.red   = near(sb.key_r, spread);
      p.green = near(sb.key_g, spread);
      p.blue  = near(sb.key_b, spread);
    end
    case ($urandom_range(0, 7))
      0: p.alpha = 8'd0;
      1: p.alpha = 8'd255;
      default: ;
    endcase
    return p;
  endfunction

  function automatic pix_t px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    pix_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    return p;
  endfunction

  task automatic run_random(input logic [7:0] en, input logic [7:0] kr,
                            input logic [7:0] kg, input logic [7:0] kb,
                            input int n, input bit hold);
    write_key(en, kr, kg, kb);
    if (hold) hold_req = 1'b1;
    repeat (n) send_pixel(pick_pixel());
    drain();
  endtask

  initial begin
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    // reset defaults: keying off
    send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(px(8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(px(8'd0, 8'd0, 8'd0, 8'd255));
    drain();

    // enable written with a wide value, only bit 0 counts
    write_key(8'h03, 8'd100, 8'd150, 8'd200);
    send_pixel(px(8'd100, 8'd150, 8'd200, 8'd255));   // on the key
    send_pixel(px(8'd106, 8'd150, 8'd200, 8'd255));   // zero band edge
    send_pixel(px(8'd94, 8'd150, 8'd200, 8'd255));
    send_pixel(px(8'd106, 8'd151, 8'd200, 8'd200));   // just past zero band
    send_pixel(px(8'd123, 8'd156, 8'd203, 8'd255));   // just below keep
    send_pixel(px(8'd124, 8'd150, 8'd200, 8'd255));   // keep edge
    send_pixel(px(8'd76, 8'd151, 8'd200, 8'd128));
    send_pixel(px(8'd115, 8'd150, 8'd200, 8'd255));   // exact half, rounds up
    send_pixel(px(8'd115, 8'd150, 8'd200, 8'd1));
    send_pixel(px(8'd100, 8'd165, 8'd200, 8'd0));
    send_pixel(px(8'd100, 8'd150, 8'd212, 8'd77));
    send_pixel(px(8'd100, 8'd150, 8'd180, 8'd255));
    send_pixel(px(8'd110, 8'd160, 8'd200, 8'd199));   // non-square distance
    send_pixel(px(8'd0, 8'd0, 8'd0, 8'd255));
    send_pixel(px(8'd255, 8'd255, 8'd255, 8'd0));
    drain();

    run_random(8'h01, 8'd0, 8'd0, 8'd0, 140, 1'b0);
    run_random(8'h01, 8'd255, 8'd255, 8'd255, 140, 1'b0);
    run_random(8'hFE, 8'($urandom), 8'($urandom), 8'($urandom), 120, 1'b0);
    run_random(8'h81, 8'($urandom), 8'($urandom), 8'($urandom), 200, 1'b1);
    run_random(8'h01, 8'd255, 8'd0, 8'd128, 140, 1'b0);
    run_random(8'h01, 8'($urandom), 8'($urandom), 8'($urandom), 140, 1'b0);
    run_random(8'h01, 8'd0, 8'd255, 8'd0, 140, 1'b0);
    run_random(8'h01, 8'($urandom), 8'($urandom), 8'($urandom), 140, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d beats checked under %0d key settings, one long output hold-off",
             sb.checked, n_settings);
    $display("alpha outcomes: %0d unkeyed, %0d zeroed, %0d ramped, %0d kept",
             sb.n_pass, sb.n_zero, sb.n_ramp, sb.n_keep);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("soft_color_key_alpha: match");
    end else begin
      $display("soft_color_key_alpha: mismatch");
    end
    $finish;
  end

endmodule
